FILE: design/lzw_pkg.sv
// ----------------------------------------------------------------------------
// LZW decoder package
// Shared constants and types for the LZW code decoder.
// ----------------------------------------------------------------------------
package lzw_pkg;

  localparam int DictEntries = 3840;
  localparam int MaxLen      = 32;
  localparam int Literals    = 128;

  localparam int CodeW  = 12;
  localparam int CharW  = $clog2(Literals);
  localparam int OutW   = 7;
  localparam int IdxW   = $clog2(DictEntries);
  localparam int PosW   = $clog2(MaxLen);
  localparam int LenW   = $clog2(MaxLen + 1);
  localparam int AddrW  = IdxW + PosW;
  localparam int MemDepth = DictEntries * MaxLen;

  typedef struct packed {
    logic             load_code;   // capture code, start lookup
    logic             read_entry;  // read dictionary char at pos
    logic             emit_step;   // advance emit position
    logic             copy_step;   // copy one previous char into the new entry
    logic             finish;      // commit new previous string
  } lzw_cmd_t;

  typedef struct packed {
    logic             is_literal;
    logic             known;
    logic             prev_empty;
    logic             last_pos;
    logic             out_ready;
    logic             copy_pending;
    logic             copy_last;
  } lzw_sts_t;

endpackage

FILE: design/lzw_code_if.sv
// ----------------------------------------------------------------------------
// LZW code channel
// Valid/ready channel carrying one input code word.
// ----------------------------------------------------------------------------
interface lzw_code_if;
  import lzw_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] code;
  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface

FILE: design/lzw_char_if.sv
// ----------------------------------------------------------------------------
// LZW character channel
// Valid/ready channel carrying one decoded character word.
// ----------------------------------------------------------------------------
interface lzw_char_if;
  import lzw_pkg::*;
  logic            valid;
  logic            ready;
  logic [OutW-1:0] out_char;
  logic            last;
  logic            overflow;
  modport source (output valid, output out_char, output last, output overflow, input ready);
  modport sink   (input valid, input out_char, input last, input overflow, output ready);
endinterface

FILE: design/lzw_cfg_if.sv
// ----------------------------------------------------------------------------
// LZW configuration channel
// Valid/ready channel carrying the restart index write word.
// ----------------------------------------------------------------------------
interface lzw_cfg_if;
  import lzw_pkg::*;
  logic             valid;
  logic             ready;
  logic [CodeW-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/lzw_code_decoder.sv
// ----------------------------------------------------------------------------
// LZW code decoder
// Decodes 12-bit LZW codes into 7-bit characters with a 3840-entry dictionary.
// ----------------------------------------------------------------------------
// One code is taken at a time. A dictionary entry alternates reads and
// emission, as each character is read from the dictionary memory before it
// is emitted. The new entry is written alongside emission; when the emitted
// string is shorter than the previous one, the rest of the entry is copied
// afterwards at one character a cycle. Entries count as written below the
// fill pointer, and all of them once the dictionary has filled once.
module lzw_code_decoder import lzw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  lzw_code_if.sink  code_i,
  lzw_char_if.source char_o,
  lzw_cfg_if.sink   cfg_i
);

  lzw_cmd_t cmd;
  lzw_sts_t sts;

  assign cfg_i.ready = 1'b1;

  lzw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (code_i.valid),
    .in_ready_o (code_i.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  lzw_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .code_i      (code_i.code),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (char_o.valid),
    .out_ready_i (char_o.ready),
    .out_char_o  (char_o.out_char),
    .out_last_o  (char_o.last),
    .out_ovf_o   (char_o.overflow)
  );

endmodule

FILE: design/lzw_datapath.sv
// ----------------------------------------------------------------------------
// LZW datapath
// Dictionary memories, previous string, fill pointer and output register.
// ----------------------------------------------------------------------------
module lzw_datapath import lzw_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lzw_cmd_t         cmd_i,
  output lzw_sts_t         sts_o,
  input  logic [CodeW-1:0] code_i,
  input  logic             cfg_we_i,
  input  logic [CodeW-1:0] cfg_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OutW-1:0]  out_char_o,
  output logic             out_last_o,
  output logic             out_ovf_o
);

  logic [CharW-1:0] entry_chars_q [MemDepth];
  logic [LenW-1:0]  entry_length_q [DictEntries];
  logic [CharW-1:0] prev_q [MaxLen];
  logic [CharW-1:0] cur_q  [MaxLen];

  logic [CodeW-1:0] restart_q;
  logic [CodeW-1:0] count_q;
  logic             full_q;
  logic [LenW-1:0]  prev_len_q;
  logic             started_q;

  logic [CodeW-1:0] code_q;
  logic [IdxW-1:0]  idx_q;
  logic             lit_q, known_q;
  logic [LenW-1:0]  n_q;
  logic [PosW-1:0]  pos_q;
  logic [PosW-1:0]  rpos_q;
  logic             ovf_q;
  logic [CharW-1:0] rd_q;
  logic [LenW-1:0]  len_rd_q;
  logic             rd_v_q;

  logic             ov_q;
  logic [OutW-1:0]  oc_q;
  logic             ol_q, oo_q;

  logic [CodeW-1:0] idx_full;
  logic             in_range;
  logic             known_now;
  logic [CharW-1:0] cur_char;
  logic             do_add;
  logic [CodeW-1:0] slot;
  logic [LenW-1:0]  new_len;
  logic [CharW-1:0] first_char;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [CharW-1:0] wr_char;

  assign idx_full = code_i - CodeW'(Literals);
  assign in_range = (code_i >= CodeW'(Literals)) && (idx_full < CodeW'(DictEntries));
  // Entries below the fill pointer are written, and all of them once the
  // dictionary has been filled once.
  assign known_now = in_range && (full_q || (idx_full < count_q));

  // Character at the current emit position.
  always_comb begin
    if (lit_q) begin
      cur_char = code_q[CharW-1:0];
    end else if (known_q) begin
      cur_char = rd_q;
    end else if (LenW'(pos_q) < prev_len_q) begin
      cur_char = prev_q[pos_q];
    end else begin
      cur_char = prev_q[0];
    end
  end

  // New entry write: previous string during emission and copy, first char last.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {slot[IdxW-1:0], pos_q};
    wr_char = prev_q[pos_q];
    if (do_add) begin
      if ((cmd_i.emit_step && LenW'(pos_q) < prev_len_q) || cmd_i.copy_step) begin
        wr_en = 1'b1;
      end else if (cmd_i.finish && prev_len_q < LenW'(MaxLen)) begin
        wr_en   = 1'b1;
        wr_addr = {slot[IdxW-1:0], prev_len_q[PosW-1:0]};
        wr_char = first_char;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_q  <= '0;
      count_q    <= '0;
      full_q     <= 1'b0;
      prev_len_q <= '0;
      started_q  <= 1'b0;
      ov_q       <= 1'b0;
      rd_v_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        restart_q <= cfg_data_i;
      end
      if (cmd_i.emit_step) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
      rd_v_q <= cmd_i.read_entry;
      if (cmd_i.finish) begin
        if (do_add) begin
          count_q <= slot + 1'b1;
          if (slot == CodeW'(DictEntries - 1)) begin
            full_q <= 1'b1;
          end
        end else if (started_q) begin
          count_q <= slot;
        end
        prev_len_q <= n_q;
        started_q  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_code) begin
      code_q  <= code_i;
      idx_q   <= idx_full[IdxW-1:0];
      lit_q   <= code_i < CodeW'(Literals);
      known_q <= known_now;
      pos_q   <= '0;
      rpos_q  <= '0;
      ovf_q   <= (code_i >= CodeW'(Literals)) && !known_now &&
                 (prev_len_q == LenW'(MaxLen));
      if (code_i < CodeW'(Literals)) begin
        n_q <= LenW'(1);
      end else if (prev_len_q == LenW'(MaxLen)) begin
        n_q <= LenW'(MaxLen);
      end else begin
        n_q <= prev_len_q + 1'b1;
      end
    end
    if (cmd_i.read_entry) begin
      rd_q     <= entry_chars_q[{idx_q, rpos_q}];
      len_rd_q <= entry_length_q[idx_q];
      rpos_q   <= rpos_q + 1'b1;
    end
    if (known_q && rd_v_q && pos_q == '0) begin
      n_q <= len_rd_q;
    end
    if (cmd_i.emit_step) begin
      cur_q[pos_q] <= cur_char;
      oc_q  <= OutW'(cur_char);
      ol_q  <= sts_o.last_pos;
      oo_q  <= ovf_q;
    end
    if (cmd_i.emit_step || cmd_i.copy_step) begin
      pos_q <= pos_q + 1'b1;
    end
    if (cmd_i.finish) begin
      for (int i = 0; i < MaxLen; i++) begin
        prev_q[i] <= cur_q[i];
      end
    end
    if (wr_en) begin
      entry_chars_q[wr_addr] <= wr_char;
    end
    if (cmd_i.finish && do_add) begin
      entry_length_q[slot[IdxW-1:0]] <= new_len;
    end
  end

  assign first_char = cur_q[0];
  assign slot = (count_q >= CodeW'(DictEntries)) ? restart_q : count_q;
  assign do_add = started_q && (slot < CodeW'(DictEntries));
  assign new_len = (prev_len_q < LenW'(MaxLen)) ? prev_len_q + 1'b1 : prev_len_q;

  assign sts_o.is_literal   = lit_q;
  assign sts_o.known        = known_q;
  assign sts_o.prev_empty   = !started_q || (prev_len_q == '0);
  assign sts_o.last_pos     = (LenW'(pos_q) + 1'b1) == n_q;
  assign sts_o.out_ready    = !ov_q || out_ready_i;
  assign sts_o.copy_pending = do_add && (n_q < prev_len_q);
  assign sts_o.copy_last    = (LenW'(pos_q) + 1'b1) == prev_len_q;

  assign out_valid_o = ov_q;
  assign out_char_o  = oc_q;
  assign out_last_o  = ol_q;
  assign out_ovf_o   = oo_q;

endmodule

FILE: design/lzw_ctrl.sv
// ----------------------------------------------------------------------------
// LZW controller
// Sequences lookup, character emission and the dictionary update.
// ----------------------------------------------------------------------------
module lzw_ctrl import lzw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output lzw_cmd_t cmd_o,
  input  lzw_sts_t sts_i
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_READ  = 6'b000100,
    S_EMIT  = 6'b001000,
    S_COPY  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o = (state_q == S_IDLE);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_code = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.is_literal) begin
          state_d = S_EMIT;
        end else if (sts_i.known) begin
          cmd_o.read_entry = 1'b1;
          state_d = S_READ;
        end else if (sts_i.prev_empty) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_READ: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_ready) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.last_pos) begin
            if (sts_i.copy_pending) begin
              state_d = S_COPY;
            end else begin
              state_d = S_DONE;
            end
          end else if (sts_i.known) begin
            cmd_o.read_entry = 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_COPY: begin
        cmd_o.copy_step = 1'b1;
        if (sts_i.copy_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LZW code decoder testbench
// Drives 12-bit codes into the decoder and checks every decoded character word
// against a behavioural dictionary model held in the bench. A directed table
// covers the literal extremes, unknown codes before and after the first code,
// codes beyond the dictionary and a growing chain up to string truncation.
// Random traffic follows under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import lzw_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int SettleCycles  = 100;

  typedef struct packed {
    logic [OutW-1:0] ch;
    logic            last;
    logic            ovf;
  } char_word_t;

  typedef enum int { EXP_MODEL, EXP_NONE, EXP_CHAR } exp_kind_e;

  typedef struct {
    int        code;
    int        reps;
    exp_kind_e kind;
    int        exp_char;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lzw_code_if code_if ();
  lzw_char_if char_if ();
  lzw_cfg_if  cfg_if ();

  lzw_code_decoder dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .code_i (code_if),
    .char_o (char_if),
    .cfg_i  (cfg_if)
  );

  logic [OutW-1:0] dict_chars [DictEntries][MaxLen];
  int              dict_len   [DictEntries];
  bit              dict_valid [DictEntries];
  int              dict_top;
  int              fill_ptr;
  int              restart_reg;
  logic [OutW-1:0] prev_chars [MaxLen];
  int              prev_len;
  bit              started;

  char_word_t pending_chars[$];
  int         err_count;
  int         idle_pct;
  int         stall_pct;
  int         quiet_cycles;
  int         chain_left;

  stim_row_t directed_rows[] = '{
    '{128, 1, EXP_NONE, 0},
    '{4095, 1, EXP_NONE, 0},
    '{0, 1, EXP_CHAR, 0},
    '{127, 1, EXP_CHAR, 127},
    '{65, 1, EXP_MODEL, 0},
    '{130, 1, EXP_MODEL, 0},
    '{131, 34, EXP_MODEL, 0},
    '{160, 1, EXP_MODEL, 0},
    '{164, 1, EXP_MODEL, 0},
    '{4000, 1, EXP_MODEL, 0},
    '{3968, 1, EXP_MODEL, 0},
    '{129, 1, EXP_MODEL, 0},
    '{1, 1, EXP_MODEL, 0},
    '{4095, 1, EXP_MODEL, 0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void decode_code(input logic [CodeW-1:0] code_val);
    logic [OutW-1:0] cur [MaxLen];
    int              n;
    int              idx;
    int              len;
    int              k;
    bit              ovf;
    char_word_t      w;
    n   = 0;
    ovf = 1'b0;
    if (code_val < Literals) begin
      cur[0] = code_val[OutW-1:0];
      n = 1;
    end else begin
      idx = code_val - Literals;
      if (idx < DictEntries && dict_valid[idx]) begin
        n = dict_len[idx];
        for (k = 0; k < n; k++) cur[k] = dict_chars[idx][k];
      end else begin
        if (!started || prev_len == 0) return;
        n = prev_len;
        for (k = 0; k < n; k++) cur[k] = prev_chars[k];
        if (n < MaxLen) begin
          cur[n] = prev_chars[0];
          n++;
        end else begin
          ovf = 1'b1;
        end
      end
    end
    if (started) begin
      if (fill_ptr >= DictEntries) fill_ptr = restart_reg;
      if (fill_ptr < DictEntries) begin
        len = prev_len;
        for (k = 0; k < len; k++) dict_chars[fill_ptr][k] = prev_chars[k];
        if (len < MaxLen) begin
          dict_chars[fill_ptr][len] = cur[0];
          len++;
        end
        dict_len[fill_ptr]   = len;
        dict_valid[fill_ptr] = 1'b1;
        fill_ptr++;
        if (fill_ptr > dict_top) dict_top = fill_ptr;
      end
    end
    for (k = 0; k < n; k++) prev_chars[k] = cur[k];
    prev_len = n;
    started  = 1'b1;
    for (k = 0; k < n; k++) begin
      w.ch   = cur[k];
      w.last = (k == n - 1);
      w.ovf  = ovf;
      pending_chars.push_back(w);
    end
  endfunction

  function automatic logic [CodeW-1:0] pick_code(input int lit_pct);
    int sel;
    int span;
    sel = $urandom_range(99);
    if (chain_left > 0 && fill_ptr < DictEntries) begin
      chain_left--;
      return CodeW'(fill_ptr + Literals);
    end
    if (sel < 4 && lit_pct < 90) begin
      chain_left = $urandom_range(34, 4);
      return CodeW'(Literals + (fill_ptr % DictEntries));
    end
    if (sel < lit_pct || dict_top == 0) return CodeW'($urandom_range(Literals - 1));
    if (sel < 88) begin
      span = (dict_top > 16) ? 15 : dict_top - 1;
      if ($urandom_range(1))
        return CodeW'(Literals + dict_top - 1 - $urandom_range(span));
      return CodeW'(Literals + $urandom_range(dict_top - 1));
    end
    if (sel < 94) return CodeW'(Literals + (fill_ptr % DictEntries));
    return CodeW'($urandom_range(4095));
  endfunction

  task automatic send_code(input logic [CodeW-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      code_if.valid <= 1'b0;
      @(negedge clk);
    end
    code_if.valid <= 1'b1;
    code_if.code  <= c;
    do @(posedge clk); while (!code_if.ready);
    decode_code(c);
    @(negedge clk);
  endtask

  task automatic write_restart(input int value);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= CodeW'(value);
    do @(posedge clk); while (!cfg_if.ready);
    restart_reg = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    code_if.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_random(input int count, input int lit_pct);
    for (int i = 0; i < count; i++) send_code(pick_code(lit_pct));
    wait_drained();
  endtask

  always @(negedge clk) begin
    char_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if ((code_if.valid && code_if.ready) || (char_if.valid && char_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_n) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, WatchdogLimit);
        $display("tb: failure");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    char_word_t exp_w;
    if (rst_n && char_if.valid && char_if.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected word char=%0d last=%0b ovf=%0b", $time,
                 char_if.out_char, char_if.last, char_if.overflow);
        err_count++;
      end else begin
        exp_w = pending_chars.pop_front();
        if (char_if.out_char !== exp_w.ch || char_if.last !== exp_w.last ||
            char_if.overflow !== exp_w.ovf) begin
          $display("%0t: mismatch expected char=%0d last=%0b ovf=%0b got char=%0d last=%0b ovf=%0b",
                   $time, exp_w.ch, exp_w.last, exp_w.ovf,
                   char_if.out_char, char_if.last, char_if.overflow);
          err_count++;
        end
      end
    end
  end

  initial begin
    char_word_t typed_w;
    int         code_val;
    code_if.valid = 1'b0;
    code_if.code  = '0;
    char_if.ready = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    rst_n         = 1'b0;
    err_count     = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    quiet_cycles  = 0;
    chain_left    = 0;
    dict_top      = 0;
    fill_ptr      = 0;
    restart_reg   = 0;
    prev_len      = 0;
    started       = 1'b0;
    for (int i = 0; i < DictEntries; i++) dict_valid[i] = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    write_restart(0);
    foreach (directed_rows[r]) begin
      for (int j = 0; j < directed_rows[r].reps; j++) begin
        code_val = directed_rows[r].code + j;
        send_code(CodeW'(code_val));
        if (directed_rows[r].kind == EXP_CHAR) begin
          void'(pending_chars.pop_back());
          typed_w.ch   = OutW'(directed_rows[r].exp_char);
          typed_w.last = 1'b1;
          typed_w.ovf  = 1'b0;
          pending_chars.push_back(typed_w);
        end
      end
    end
    wait_drained();

    run_random(30, 35);
    idle_pct = 53;
    run_random(30, 35);
    idle_pct  = 0;
    stall_pct = 53;
    run_random(30, 35);
    idle_pct  = 26;
    stall_pct = 26;
    run_random(30, 35);

    if (err_count == 0 && pending_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lzw_pkg.sv
design/lzw_code_if.sv
design/lzw_char_if.sv
design/lzw_cfg_if.sv
design/lzw_datapath.sv
design/lzw_ctrl.sv
design/lzw_code_decoder.sv
tb/tb_top.sv
